FILE: hdl/rotated_rect_overlap_test_macros.svh
// Assertion macros shared by the overlap test RTL.
`ifndef ROTATED_RECT_OVERLAP_TEST_MACROS_SVH
`define ROTATED_RECT_OVERLAP_TEST_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, masked during reset.
`define RROT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rrot assertion failed");
// Next-cycle implication, also checked through reset.
`define RROT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("rrot assertion failed");
`else
`define RROT_ASSERT_IMP(lbl, ante, cons)
`define RROT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/rrot_pkg.sv
// Shared constants, types and trig table builder for the overlap test.
package rrot_pkg;
    localparam int TRIG_BITS  = 16;
    localparam int TRIG_W     = TRIG_BITS + 2;
    localparam int GEOM_W     = 16;
    localparam int PROD_W     = GEOM_W + TRIG_W;
    localparam int CORN_W     = TRIG_BITS + 20;
    localparam int PMUL_W     = CORN_W + TRIG_W;
    localparam int PROJ_W     = PMUL_W + 1;
    localparam int OCT_N      = 721;
    localparam int ROM_AW     = 10;
    localparam int LAT        = 9;

    localparam logic [12:0] FULL_TURN    = 13'd5760;
    localparam logic [12:0] THREE_QTR    = 13'd4320;
    localparam logic [12:0] HALF_TURN    = 13'd2880;
    localparam logic [12:0] QUARTER_TURN = 13'd1440;
    localparam logic [12:0] EIGHTH_TURN  = 13'd720;

    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned PI_Q30  = 64'd3373259426;

    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [CORN_W-1:0] corner_t;
    typedef logic signed [PMUL_W-1:0] pmul_t;
    typedef logic signed [PROJ_W-1:0] proj_t;
    typedef logic [2*TRIG_W-1:0]      rom_word_t;
    typedef rom_word_t                rom_image_t [OCT_N];

    function automatic longint unsigned q30_angle(input longint unsigned r);
        return (r * PI_Q30 + 64'd1440) / 2880;
    endfunction

    function automatic longint unsigned round_trig(input longint unsigned v);
        return (v + (64'd1 << (29 - TRIG_BITS))) >> (30 - TRIG_BITS);
    endfunction

    function automatic longint unsigned oct_sin(input longint unsigned r);
        longint unsigned x, x2, t;
        x  = q30_angle(r);
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        return round_trig((x * t) >> 30);
    endfunction

    function automatic longint unsigned oct_cos(input longint unsigned r);
        longint unsigned x, x2, t;
        x  = q30_angle(r);
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 132;
        t  = Q30_ONE - ((x2 * t) >> 30) / 90;
        t  = Q30_ONE - ((x2 * t) >> 30) / 56;
        t  = Q30_ONE - ((x2 * t) >> 30) / 30;
        t  = Q30_ONE - ((x2 * t) >> 30) / 12;
        t  = Q30_ONE - ((x2 * t) >> 30) / 2;
        return round_trig(t);
    endfunction

    // Word layout: sine in the upper half, cosine in the lower half.
    function automatic rom_image_t build_rom();
        rom_image_t img;
        longint unsigned s, c;
        for (int i = 0; i < OCT_N; i++) begin
            s = oct_sin(longint'(i));
            c = oct_cos(longint'(i));
            img[i] = {s[TRIG_W-1:0], c[TRIG_W-1:0]};
        end
        return img;
    endfunction
endpackage

FILE: hdl/rrot_trig_rom.sv
// First-octant sine/cosine ROM with registered read.
module rrot_trig_rom (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [rrot_pkg::ROM_AW-1:0] addr,
    output rrot_pkg::rom_word_t       data
);
    import rrot_pkg::*;

    localparam rom_image_t ROM = build_rom();

    rom_word_t data_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= ROM[addr];
        end
    end

    assign data = data_reg;
endmodule

FILE: hdl/rrot_corner.sv
// Angle fold, trig lookup and corner rotation for one rectangle.
module rrot_corner (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [15:0]    x,
    input  logic signed [15:0]    y,
    input  logic [14:0]           w,
    input  logic [14:0]           h,
    input  logic [12:0]           angle,
    output rrot_pkg::corner_t     px [4],
    output rrot_pkg::corner_t     py [4],
    output rrot_pkg::trig_t       sn,
    output rrot_pkg::trig_t       cs,
    output logic                  live_w,
    output logic                  live_h
);
    import rrot_pkg::*;

    // stage 1: fold the angle
    logic [12:0]       ang_wrap;
    logic [1:0]        q_next;
    logic [12:0]       r_next;
    logic              swap_next;
    logic [ROM_AW-1:0] idx_next;

    logic [1:0]        q1_reg;
    logic              swap1_reg;
    logic [ROM_AW-1:0] idx1_reg;
    logic signed [15:0] x1_reg, y1_reg;
    logic [14:0]       w1_reg, h1_reg;

    always_comb begin
        ang_wrap = (angle >= FULL_TURN) ? angle - FULL_TURN : angle;
        priority if (ang_wrap >= THREE_QTR) begin
            q_next = 2'd3;
            r_next = ang_wrap - THREE_QTR;
        end else if (ang_wrap >= HALF_TURN) begin
            q_next = 2'd2;
            r_next = ang_wrap - HALF_TURN;
        end else if (ang_wrap >= QUARTER_TURN) begin
            q_next = 2'd1;
            r_next = ang_wrap - QUARTER_TURN;
        end else begin
            q_next = 2'd0;
            r_next = ang_wrap;
        end
        swap_next = r_next > EIGHTH_TURN;
        idx_next  = swap_next ? ROM_AW'(QUARTER_TURN - r_next) : ROM_AW'(r_next);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q1_reg    <= q_next;
            swap1_reg <= swap_next;
            idx1_reg  <= idx_next;
            x1_reg    <= x;
            y1_reg    <= y;
            w1_reg    <= w;
            h1_reg    <= h;
        end
    end

    // stage 2: table read
    rom_word_t rom_data;

    rrot_trig_rom u_rom (
        .aclk (aclk),
        .en   (en),
        .addr (idx1_reg),
        .data (rom_data)
    );

    logic [1:0]         q2_reg;
    logic               swap2_reg;
    logic signed [15:0] x2_reg, y2_reg;
    logic [14:0]        w2_reg, h2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            q2_reg    <= q1_reg;
            swap2_reg <= swap1_reg;
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            w2_reg    <= w1_reg;
            h2_reg    <= h1_reg;
        end
    end

    // stage 3: octant swap and quadrant signs
    trig_t sr, cr, sn_next, cs_next;
    trig_t sn3_reg, cs3_reg;
    logic signed [15:0] x3_reg, y3_reg;
    logic [14:0]        w3_reg, h3_reg;

    always_comb begin
        sr = swap2_reg ? trig_t'(rom_data[TRIG_W-1:0]) : trig_t'(rom_data[2*TRIG_W-1:TRIG_W]);
        cr = swap2_reg ? trig_t'(rom_data[2*TRIG_W-1:TRIG_W]) : trig_t'(rom_data[TRIG_W-1:0]);
        unique case (q2_reg)
            2'd0: begin sn_next = sr;  cs_next = cr;  end
            2'd1: begin sn_next = cr;  cs_next = -sr; end
            2'd2: begin sn_next = -sr; cs_next = -cr; end
            default: begin sn_next = -cr; cs_next = sr; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sn3_reg <= sn_next;
            cs3_reg <= cs_next;
            x3_reg  <= x2_reg;
            y3_reg  <= y2_reg;
            w3_reg  <= w2_reg;
            h3_reg  <= h2_reg;
        end
    end

    // stage 4: extent products and doubled center
    logic signed [15:0] ws, hs;
    logic signed [17:0] c2x, c2y;
    prod_t   wc4_reg, hs4_reg, ws4_reg, hc4_reg;
    corner_t cx4_reg, cy4_reg;
    trig_t   sn4_reg, cs4_reg;
    logic    lw4_reg, lh4_reg;

    assign ws  = signed'({1'b0, w3_reg});
    assign hs  = signed'({1'b0, h3_reg});
    assign c2x = signed'({x3_reg[15], x3_reg, 1'b0}) + signed'({3'b000, w3_reg});
    assign c2y = signed'({y3_reg[15], y3_reg, 1'b0}) + signed'({3'b000, h3_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            wc4_reg <= PROD_W'(ws * cs3_reg);
            hs4_reg <= PROD_W'(hs * sn3_reg);
            ws4_reg <= PROD_W'(ws * sn3_reg);
            hc4_reg <= PROD_W'(hs * cs3_reg);
            cx4_reg <= {{(CORN_W-18-TRIG_BITS){c2x[17]}}, c2x, {TRIG_BITS{1'b0}}};
            cy4_reg <= {{(CORN_W-18-TRIG_BITS){c2y[17]}}, c2y, {TRIG_BITS{1'b0}}};
            sn4_reg <= sn3_reg;
            cs4_reg <= cs3_reg;
            lw4_reg <= w3_reg != '0;
            lh4_reg <= h3_reg != '0;
        end
    end

    // stage 5: corners, order (-w,+h) (+w,+h) (+w,-h) (-w,-h)
    corner_t wc, hsn, wsn, hc;
    corner_t px5_reg [4];
    corner_t py5_reg [4];
    trig_t   sn5_reg, cs5_reg;
    logic    lw5_reg, lh5_reg;

    assign wc  = CORN_W'(wc4_reg);
    assign hsn = CORN_W'(hs4_reg);
    assign wsn = CORN_W'(ws4_reg);
    assign hc  = CORN_W'(hc4_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            px5_reg[0] <= cx4_reg - wc - hsn;
            py5_reg[0] <= cy4_reg - wsn + hc;
            px5_reg[1] <= cx4_reg + wc - hsn;
            py5_reg[1] <= cy4_reg + wsn + hc;
            px5_reg[2] <= cx4_reg + wc + hsn;
            py5_reg[2] <= cy4_reg + wsn - hc;
            px5_reg[3] <= cx4_reg - wc + hsn;
            py5_reg[3] <= cy4_reg - wsn - hc;
            sn5_reg    <= sn4_reg;
            cs5_reg    <= cs4_reg;
            lw5_reg    <= lw4_reg;
            lh5_reg    <= lh4_reg;
        end
    end

    assign px     = px5_reg;
    assign py     = py5_reg;
    assign sn     = sn5_reg;
    assign cs     = cs5_reg;
    assign live_w = lw5_reg;
    assign live_h = lh5_reg;
endmodule

FILE: hdl/rrot_sat.sv
// Projection of both corner sets onto four axes and interval compare.
module rrot_sat (
    input  logic                 aclk,
    input  logic                 en,
    input  rrot_pkg::corner_t    a_px [4],
    input  rrot_pkg::corner_t    a_py [4],
    input  rrot_pkg::corner_t    b_px [4],
    input  rrot_pkg::corner_t    b_py [4],
    input  rrot_pkg::trig_t      a_sn,
    input  rrot_pkg::trig_t      a_cs,
    input  rrot_pkg::trig_t      b_sn,
    input  rrot_pkg::trig_t      b_cs,
    input  logic [3:0]           live,
    output logic                 colliding
);
    import rrot_pkg::*;

    trig_t ux [4];
    trig_t uy [4];

    assign ux[0] = a_cs;  assign uy[0] = a_sn;
    assign ux[1] = -a_sn; assign uy[1] = a_cs;
    assign ux[2] = b_cs;  assign uy[2] = b_sn;
    assign ux[3] = -b_sn; assign uy[3] = b_cs;

    // stage 6: products, [axis][corner]
    pmul_t ax_reg [4][4];
    pmul_t ay_reg [4][4];
    pmul_t bx_reg [4][4];
    pmul_t by_reg [4][4];
    logic [3:0] live6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                for (int k = 0; k < 4; k++) begin
                    ax_reg[i][k] <= PMUL_W'(a_px[k] * ux[i]);
                    ay_reg[i][k] <= PMUL_W'(a_py[k] * uy[i]);
                    bx_reg[i][k] <= PMUL_W'(b_px[k] * ux[i]);
                    by_reg[i][k] <= PMUL_W'(b_py[k] * uy[i]);
                end
            end
            live6_reg <= live;
        end
    end

    // stage 7: projections
    proj_t pa_reg [4][4];
    proj_t pb_reg [4][4];
    logic [3:0] live7_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                for (int k = 0; k < 4; k++) begin
                    pa_reg[i][k] <= PROJ_W'(ax_reg[i][k]) + PROJ_W'(ay_reg[i][k]);
                    pb_reg[i][k] <= PROJ_W'(bx_reg[i][k]) + PROJ_W'(by_reg[i][k]);
                end
            end
            live7_reg <= live6_reg;
        end
    end

    // stage 8: interval ends, pairwise tree
    proj_t mna_next [4], mxa_next [4], mnb_next [4], mxb_next [4];
    proj_t mna_reg [4], mxa_reg [4], mnb_reg [4], mxb_reg [4];
    logic [3:0] live8_reg;

    always_comb begin
        proj_t l0, l1, h0, h1, l2, l3, h2, h3;
        for (int i = 0; i < 4; i++) begin
            l0 = (pa_reg[i][0] < pa_reg[i][1]) ? pa_reg[i][0] : pa_reg[i][1];
            h0 = (pa_reg[i][0] < pa_reg[i][1]) ? pa_reg[i][1] : pa_reg[i][0];
            l1 = (pa_reg[i][2] < pa_reg[i][3]) ? pa_reg[i][2] : pa_reg[i][3];
            h1 = (pa_reg[i][2] < pa_reg[i][3]) ? pa_reg[i][3] : pa_reg[i][2];
            l2 = (pb_reg[i][0] < pb_reg[i][1]) ? pb_reg[i][0] : pb_reg[i][1];
            h2 = (pb_reg[i][0] < pb_reg[i][1]) ? pb_reg[i][1] : pb_reg[i][0];
            l3 = (pb_reg[i][2] < pb_reg[i][3]) ? pb_reg[i][2] : pb_reg[i][3];
            h3 = (pb_reg[i][2] < pb_reg[i][3]) ? pb_reg[i][3] : pb_reg[i][2];
            mna_next[i] = (l0 < l1) ? l0 : l1;
            mxa_next[i] = (h0 < h1) ? h1 : h0;
            mnb_next[i] = (l2 < l3) ? l2 : l3;
            mxb_next[i] = (h2 < h3) ? h3 : h2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mna_reg   <= mna_next;
            mxa_reg   <= mxa_next;
            mnb_reg   <= mnb_next;
            mxb_reg   <= mxb_next;
            live8_reg <= live7_reg;
        end
    end

    // stage 9: any live axis with a gap separates
    logic [3:0] sep;
    logic       coll_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sep[i] = live8_reg[i] && ((mxa_reg[i] < mnb_reg[i]) || (mxb_reg[i] < mna_reg[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            coll_reg <= ~|sep;
        end
    end

    assign colliding = coll_reg;
endmodule

FILE: hdl/rotated_rect_overlap_test.sv
// Top level: oriented rectangle pair collision test pipeline.
//
// Use: present one rectangle pair per beat on the s_ channel (corner, size
// and angle of rectangles A and B); one beat with m_colliding comes back on
// the m_ channel for every accepted pair, in order.
// Throughput: one pair per cycle while m_ready keeps up. Stages: angle fold,
// trig ROM read, quadrant signs, extent products, corners, projection
// products, projection sums, interval min/max, axis compare. The trig ROM
// read port and the 18-bit by 36-bit projection multipliers set the stage
// depth.
// Stall: the whole pipeline advances as one; when m_valid is high and
// m_ready low every stage holds, and s_ready drops in the same cycle, so no
// beat is lost or repeated. Bubbles travel as cleared valid bits.
// Reset: aresetn (synchronous, active low) clears only the valid bits; the
// data registers are left as they are. m_valid is low after reset.
// The sine/cosine table covers one octant (721 entries) and is built when
// the design is elaborated.
`include "rotated_rect_overlap_test_macros.svh"
module rotated_rect_overlap_test (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_a_x,
    input  logic signed [15:0] s_a_y,
    input  logic [14:0]        s_a_w,
    input  logic [14:0]        s_a_h,
    input  logic [12:0]        s_a_angle,
    input  logic signed [15:0] s_b_x,
    input  logic signed [15:0] s_b_y,
    input  logic [14:0]        s_b_w,
    input  logic [14:0]        s_b_h,
    input  logic [12:0]        s_b_angle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_colliding
);
    import rrot_pkg::*;

    // advance every stage when the output slot is free or being taken
    logic en;
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    logic [LAT-1:0] v_reg, v_next;

    always_comb begin
        v_next = v_reg;
        if (en) begin
            v_next = {v_reg[LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign m_valid = v_reg[LAT-1];

    corner_t a_px [4], a_py [4], b_px [4], b_py [4];
    trig_t   a_sn, a_cs, b_sn, b_cs;
    logic    a_lw, a_lh, b_lw, b_lh;

    rrot_corner u_corner_a (
        .aclk   (aclk),
        .en     (en),
        .x      (s_a_x),
        .y      (s_a_y),
        .w      (s_a_w),
        .h      (s_a_h),
        .angle  (s_a_angle),
        .px     (a_px),
        .py     (a_py),
        .sn     (a_sn),
        .cs     (a_cs),
        .live_w (a_lw),
        .live_h (a_lh)
    );

    rrot_corner u_corner_b (
        .aclk   (aclk),
        .en     (en),
        .x      (s_b_x),
        .y      (s_b_y),
        .w      (s_b_w),
        .h      (s_b_h),
        .angle  (s_b_angle),
        .px     (b_px),
        .py     (b_py),
        .sn     (b_sn),
        .cs     (b_cs),
        .live_w (b_lw),
        .live_h (b_lh)
    );

    rrot_sat u_sat (
        .aclk      (aclk),
        .en        (en),
        .a_px      (a_px),
        .a_py      (a_py),
        .b_px      (b_px),
        .b_py      (b_py),
        .a_sn      (a_sn),
        .a_cs      (a_cs),
        .b_sn      (b_sn),
        .b_cs      (b_cs),
        .live      ({b_lh, b_lw, a_lh, a_lw}),
        .colliding (m_colliding)
    );

    // reset empties the pipeline
    `RROT_ASSERT_NXT(a_rst_empty, !aresetn, !m_valid)
    // a stalled output blocks the input
    `RROT_ASSERT_IMP(a_stall_back, m_valid && !m_ready, !s_ready)
    // a new result only appears after the pipeline advanced
    `RROT_ASSERT_IMP(a_rise_adv, $rose(m_valid), $past(s_ready))
endmodule
